@@ hw/rtl/scts_pkg.sv @@
// scts_pkg: shared types, fixed-point constants, reciprocal table and microcode
// for the sine/cosine/tangent series block. No dependencies.
package scts_pkg;

  // Function codes carried in the mode field
  localparam logic [1:0] MODE_SIN = 2'd0;
  localparam logic [1:0] MODE_COS = 2'd1;
  localparam logic [1:0] MODE_TAN = 2'd2;

  // Series length default and term index width (TERMS range 1..16)
  localparam int TERMS_DEF = 10;
  localparam int IDX_W     = 4;

  // Datapath widths (Q29 working values)
  localparam int X_W    = 35;   // angle before reduction
  localparam int X2_W   = 33;   // x^2, non-negative
  localparam int Q_W    = 31;   // x^2 / ((2i+2)(2i+3))
  localparam int TERM_W = 34;   // signed series term
  localparam int SUM_W  = 36;   // signed partial sum
  localparam int MA_W   = 33;   // multiplier operand A magnitude
  localparam int MB_W   = 32;   // multiplier operand B magnitude
  localparam int PROD_W = MA_W + MB_W;
  localparam int MAG_W  = 34;   // |sine|, |cosine|
  localparam int NUM_W  = MAG_W + 24;
  localparam int QUO_W  = 33;   // tangent quotient bits
  localparam int DSH_W  = MAG_W + QUO_W - 1;
  localparam int CNT_W  = 6;

  // Q29 constants
  localparam logic signed [X_W-1:0] PI_Q29      = 35'sd1686629713;
  localparam logic signed [X_W-1:0] TWO_PI_Q29  = 35'sd3373259426;
  localparam logic signed [X_W-1:0] HALF_PI_Q29 = 35'sd843314857;

  // Item payloads
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] angle;
  } scts_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               overflow;
  } scts_out_t;

  // Micro-operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_HPI,      // add pi/2 for cosine
    OP_RED,      // one 2*pi reduction step
    OP_MXX,      // start x*x, init series
    OP_X2,       // latch x^2
    OP_ACC,      // sum += term
    OP_MXR,      // start x^2 * reciprocal
    OP_Q,        // latch coefficient
    OP_MTQ,      // start term * coefficient
    OP_TERM,     // latch next term
    OP_PASS,     // tangent: save sine, restart for cosine
    OP_OUT_SC,   // emit sine/cosine
    OP_DINIT,    // tangent divider setup
    OP_DSTEP,    // one quotient bit
    OP_OUT_TAN   // emit tangent
  } scts_op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_LAST,
    C_TAN_FIRST,
    C_TAN,
    C_DMORE
  } scts_cond_t;

  localparam int PC_W = 5;

  typedef struct packed {
    scts_op_t         op;
    scts_cond_t       cond;
    logic [PC_W-1:0]  target;
    logic             last;
  } scts_ucode_t;

  // Status flags from datapath to sequencer
  typedef struct packed {
    logic last_term;
    logic tan_first;
    logic is_tan;
    logic div_more;
  } scts_stat_t;

  // Program addresses used as jump targets
  localparam logic [PC_W-1:0] PC_START = 5'd0;
  localparam logic [PC_W-1:0] PC_ACC   = 5'd6;
  localparam logic [PC_W-1:0] PC_PASS  = 5'd11;
  localparam logic [PC_W-1:0] PC_DINIT = 5'd14;
  localparam logic [PC_W-1:0] PC_DSTEP = 5'd15;

  // Control store
  function automatic scts_ucode_t ucode(input logic [PC_W-1:0] pc);
    scts_ucode_t w;
    w.op     = OP_NOP;
    w.cond   = C_NONE;
    w.target = PC_START;
    w.last   = 1'b0;
    case (pc)
      5'd0:  w.op = OP_HPI;
      5'd1:  w.op = OP_RED;
      5'd2:  w.op = OP_RED;
      5'd3:  w.op = OP_RED;
      5'd4:  w.op = OP_MXX;
      5'd5:  w.op = OP_X2;
      5'd6:  begin
        w.op = OP_ACC; w.cond = C_LAST; w.target = PC_PASS;
      end
      5'd7:  w.op = OP_MXR;
      5'd8:  w.op = OP_Q;
      5'd9:  w.op = OP_MTQ;
      5'd10: begin
        w.op = OP_TERM; w.cond = C_ALWAYS; w.target = PC_ACC;
      end
      5'd11: begin
        w.op = OP_PASS; w.cond = C_TAN_FIRST; w.target = PC_START;
      end
      5'd12: begin
        w.cond = C_TAN; w.target = PC_DINIT;
      end
      5'd13: begin
        w.op = OP_OUT_SC; w.last = 1'b1;
      end
      5'd14: w.op = OP_DINIT;
      5'd15: begin
        w.op = OP_DSTEP; w.cond = C_DMORE; w.target = PC_DSTEP;
      end
      5'd16: begin
        w.op = OP_OUT_TAN; w.last = 1'b1;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

  // round(2^32 / ((2i+2)(2i+3)))
  function automatic logic [MB_W-1:0] recip(input logic [IDX_W-1:0] i);
    logic [MB_W-1:0] r;
    case (i)
      4'd0:    r = 32'd715827883;
      4'd1:    r = 32'd214748365;
      4'd2:    r = 32'd102261126;
      4'd3:    r = 32'd59652324;
      4'd4:    r = 32'd39045157;
      4'd5:    r = 32'd27531842;
      4'd6:    r = 32'd20452225;
      4'd7:    r = 32'd15790321;
      4'd8:    r = 32'd12558384;
      4'd9:    r = 32'd10226113;
      4'd10:   r = 32'd8488078;
      4'd11:   r = 32'd7158279;
      4'd12:   r = 32'd6118187;
      4'd13:   r = 32'd5289369;
      4'd14:   r = 32'd4618244;
      4'd15:   r = 32'd4067204;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/scts_mul.sv @@
// scts_mul: shared unsigned multiplier with registered product and sign.
// Depends on scts_pkg.
module scts_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [scts_pkg::MA_W-1:0]    a,
  input  logic [scts_pkg::MB_W-1:0]    b,
  input  logic                         neg,
  output logic [scts_pkg::PROD_W-1:0]  prod,
  output logic                         prod_neg
);

  logic [scts_pkg::PROD_W-1:0] prod_r;
  logic                        neg_r;

  // Product register; sign travels alongside
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= scts_pkg::PROD_W'(a) * scts_pkg::PROD_W'(b);
      neg_r  <= neg;
    end
  end

  assign prod     = prod_r;
  assign prod_neg = neg_r;

endmodule

@@ hw/rtl/scts_seq.sv @@
// scts_seq: microcode sequencer - step counter, control store, conditional jumps.
// Depends on scts_pkg.
module scts_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  stall,
  input  scts_pkg::scts_stat_t  stat,
  output scts_pkg::scts_ucode_t cw,
  output logic                  run
);

  logic [scts_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      run_r, run_nxt;
  logic                      take;

  assign cw  = scts_pkg::ucode(pc_r);
  assign run = run_r;

  // Jump condition select
  always_comb begin
    case (cw.cond)
      scts_pkg::C_NONE:      take = 1'b0;
      scts_pkg::C_ALWAYS:    take = 1'b1;
      scts_pkg::C_LAST:      take = stat.last_term;
      scts_pkg::C_TAN_FIRST: take = stat.tan_first;
      scts_pkg::C_TAN:       take = stat.is_tan;
      scts_pkg::C_DMORE:     take = stat.div_more;
      default:               take = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    pc_nxt  = pc_r;
    run_nxt = run_r;
    if (!run_r) begin
      pc_nxt = scts_pkg::PC_START;
      if (start) run_nxt = 1'b1;
    end else if (!stall) begin
      if (cw.last) begin
        run_nxt = 1'b0;
        pc_nxt  = scts_pkg::PC_START;
      end else if (take) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= scts_pkg::PC_START;
      run_r <= 1'b0;
    end else begin
      pc_r  <= pc_nxt;
      run_r <= run_nxt;
    end
  end

endmodule

@@ hw/rtl/scts_dp.sv @@
// scts_dp: angle reduction, series accumulation and tangent divider datapath.
// Depends on scts_pkg and scts_mul.
module scts_dp #(
  parameter int TERMS = scts_pkg::TERMS_DEF
) (
  input  logic                  clk,
  input  logic                  load,
  input  scts_pkg::scts_in_t    in_item,
  input  scts_pkg::scts_op_t    op,
  output scts_pkg::scts_stat_t  stat,
  output scts_pkg::scts_out_t   res
);

  localparam int X_W    = scts_pkg::X_W;
  localparam int X2_W   = scts_pkg::X2_W;
  localparam int Q_W    = scts_pkg::Q_W;
  localparam int TERM_W = scts_pkg::TERM_W;
  localparam int SUM_W  = scts_pkg::SUM_W;
  localparam int MA_W   = scts_pkg::MA_W;
  localparam int MB_W   = scts_pkg::MB_W;
  localparam int PROD_W = scts_pkg::PROD_W;
  localparam int MAG_W  = scts_pkg::MAG_W;
  localparam int NUM_W  = scts_pkg::NUM_W;
  localparam int DSH_W  = scts_pkg::DSH_W;
  localparam int QUO_W  = scts_pkg::QUO_W;
  localparam int CNT_W  = scts_pkg::CNT_W;
  localparam int IDX_W  = scts_pkg::IDX_W;

  logic [1:0]               mode_r;
  logic                     pass_r;
  logic signed [31:0]       ang_r;
  logic signed [X_W-1:0]    x_r;
  logic [X2_W-1:0]          x2_r;
  logic [Q_W-1:0]           q_r;
  logic signed [TERM_W-1:0] term_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  s_r;
  logic [IDX_W-1:0]         i_r;
  logic [NUM_W-1:0]         rem_r;
  logic [DSH_W-1:0]         dsh_r;
  logic [QUO_W-1:0]         quo_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     dneg_r, dzero_r, dsat_r, sneg_r;

  // Multiplier hookup
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic              mul_neg, mul_en;
  logic [PROD_W-1:0] prod;
  logic              prod_neg;

  logic [X_W-1:0]    x_mag;
  logic [TERM_W-1:0] term_mag;
  logic [PROD_W-1:0] r29, r32;
  logic [TERM_W-1:0] t_mag;

  logic [SUM_W-1:0]  sum_mag, s_mag_w;
  logic [MAG_W-1:0]  s_mag, c_mag;
  logic [NUM_W-1:0]  num;
  logic              pre_ovf;
  logic              div_ge;

  logic [31:0]        q24_m;
  logic signed [32:0] q24_v;
  logic [31:0]        q24_val;

  assign x_mag    = x_r[X_W-1] ? X_W'(-x_r) : X_W'(x_r);
  assign term_mag = term_r[TERM_W-1] ? TERM_W'(-term_r) : TERM_W'(term_r);

  // Operand select for the shared multiplier
  always_comb begin
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (op)
      scts_pkg::OP_MXX: begin
        mul_en = 1'b1;
        mul_a  = x_mag[MA_W-1:0];
        mul_b  = x_mag[MB_W-1:0];
      end
      scts_pkg::OP_MXR: begin
        mul_en = 1'b1;
        mul_a  = x2_r;
        mul_b  = scts_pkg::recip(i_r);
      end
      scts_pkg::OP_MTQ: begin
        // next term is the negated product
        mul_en  = 1'b1;
        mul_a   = term_mag[MA_W-1:0];
        mul_b   = MB_W'(q_r);
        mul_neg = ~term_r[TERM_W-1];
      end
      default: mul_en = 1'b0;
    endcase
  end

  scts_mul u_mul (
    .clk      (clk),
    .en       (mul_en),
    .a        (mul_a),
    .b        (mul_b),
    .neg      (mul_neg),
    .prod     (prod),
    .prod_neg (prod_neg)
  );

  // Round to nearest, ties away from zero, on magnitudes
  assign r29   = (prod + (PROD_W'(1) << 28)) >> 29;
  assign r32   = (prod + (PROD_W'(1) << 31)) >> 32;
  assign t_mag = r29[TERM_W-1:0];

  // Tangent divider setup values
  assign s_mag_w = s_r[SUM_W-1] ? SUM_W'(-s_r) : SUM_W'(s_r);
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign s_mag   = s_mag_w[MAG_W-1:0];
  assign c_mag   = sum_mag[MAG_W-1:0];
  assign num     = {s_mag, 24'b0} + NUM_W'(c_mag >> 1);
  assign pre_ovf = {(DSH_W + 1 - NUM_W)'(0), num} >= {c_mag, QUO_W'(0)};
  assign div_ge  = {(DSH_W - NUM_W)'(0), rem_r} >= dsh_r;

  // Sum in Q29 to Q24 with rounding and saturation
  assign q24_m = 32'((37'(sum_mag) + 37'd16) >> 5);
  assign q24_v = sum_r[SUM_W-1] ? -$signed({1'b0, q24_m}) : $signed({1'b0, q24_m});
  always_comb begin
    if (!q24_v[32] && q24_v[31])     q24_val = 32'h7FFF_FFFF;
    else if (q24_v[32] && !q24_v[31]) q24_val = 32'h8000_0000;
    else                              q24_val = q24_v[31:0];
  end

  // Result word for the two output steps
  always_comb begin
    res.value    = '0;
    res.overflow = 1'b0;
    case (op)
      scts_pkg::OP_OUT_SC: begin
        if (mode_r == scts_pkg::MODE_SIN || mode_r == scts_pkg::MODE_COS)
          res.value = q24_val;
      end
      scts_pkg::OP_OUT_TAN: begin
        if (dzero_r) begin
          res.value    = sneg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
          res.overflow = 1'b1;
        end else if (dsat_r) begin
          res.value    = dneg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
          res.overflow = 1'b1;
        end else if (!dneg_r && quo_r > QUO_W'(32'h7FFF_FFFF)) begin
          res.value    = 32'h7FFF_FFFF;
          res.overflow = 1'b1;
        end else if (dneg_r && quo_r > QUO_W'(32'h8000_0000)) begin
          res.value    = 32'h8000_0000;
          res.overflow = 1'b1;
        end else begin
          res.value = dneg_r ? -quo_r[31:0] : quo_r[31:0];
        end
      end
      default: res.overflow = 1'b0;
    endcase
  end

  // Status for jumps
  assign stat.last_term = (i_r == IDX_W'(TERMS - 1));
  assign stat.is_tan    = (mode_r == scts_pkg::MODE_TAN);
  assign stat.tan_first = (mode_r == scts_pkg::MODE_TAN) && !pass_r;
  assign stat.div_more  = (cnt_r != '0);

  // Working registers
  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= in_item.mode;
      ang_r  <= in_item.angle;
      pass_r <= 1'b0;
      x_r    <= {{2{in_item.angle[31]}}, in_item.angle, 1'b0};
    end else begin
      case (op)
        scts_pkg::OP_HPI: begin
          if (mode_r == scts_pkg::MODE_COS || pass_r)
            x_r <= x_r + scts_pkg::HALF_PI_Q29;
        end
        scts_pkg::OP_RED: begin
          if (x_r > scts_pkg::PI_Q29)
            x_r <= x_r - scts_pkg::TWO_PI_Q29;
          else if (x_r < -scts_pkg::PI_Q29)
            x_r <= x_r + scts_pkg::TWO_PI_Q29;
        end
        scts_pkg::OP_MXX: begin
          term_r <= TERM_W'(x_r);
          sum_r  <= '0;
          i_r    <= '0;
        end
        scts_pkg::OP_X2:  x2_r <= r29[X2_W-1:0];
        scts_pkg::OP_ACC: sum_r <= sum_r + SUM_W'(term_r);
        scts_pkg::OP_Q:   q_r <= r32[Q_W-1:0];
        scts_pkg::OP_TERM: begin
          term_r <= prod_neg ? -$signed(t_mag) : $signed(t_mag);
          i_r    <= i_r + 1'b1;
        end
        scts_pkg::OP_PASS: begin
          // tangent: keep sine, rerun on the same angle for cosine
          if (mode_r == scts_pkg::MODE_TAN && !pass_r) begin
            s_r    <= sum_r;
            pass_r <= 1'b1;
            x_r    <= {{2{ang_r[31]}}, ang_r, 1'b0};
          end
        end
        scts_pkg::OP_DINIT: begin
          rem_r   <= num;
          dsh_r   <= {c_mag, (QUO_W - 1)'(0)};
          quo_r   <= '0;
          cnt_r   <= CNT_W'(QUO_W - 1);
          dneg_r  <= s_r[SUM_W-1] ^ sum_r[SUM_W-1];
          sneg_r  <= s_r[SUM_W-1];
          dzero_r <= (c_mag == '0);
          dsat_r  <= pre_ovf;
        end
        scts_pkg::OP_DSTEP: begin
          if (div_ge) rem_r <= rem_r - dsh_r[NUM_W-1:0];
          quo_r <= {quo_r[QUO_W-2:0], div_ge};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r - 1'b1;
        end
        default: x_r <= x_r;
      endcase
    end
  end

endmodule

@@ hw/rtl/sine_cosine_tangent_series_top.sv @@
// Top level: input/output handshakes, result register, sequencer and datapath.
// Depends on scts_pkg, scts_seq, scts_dp (and scts_mul below it).
//
// Computes sine, cosine or tangent of a signed Q3.28 radian angle and returns a
// saturated signed Q7.24 value with an overflow flag (tangent only). One item is
// processed at a time by a microcoded sequencer driving one shared multiplier.
// Each series term is an accumulate plus two dependent passes through the
// registered multiplier (x^2 times a reciprocal, then the term times that
// coefficient); tangent runs the series twice and then a radix-2 divider
// producing 33 quotient bits, one per cycle. The result register lets a new
// item be accepted while the previous result is still waiting to be taken.
module sine_cosine_tangent_series_top #(
  parameter int TERMS = scts_pkg::TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scts_pkg::scts_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scts_pkg::scts_out_t out_data
);

  scts_pkg::scts_ucode_t cw;
  scts_pkg::scts_stat_t  stat;
  scts_pkg::scts_op_t    dp_op;
  scts_pkg::scts_out_t   res;
  scts_pkg::scts_out_t   out_data_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  run, start, stall, is_out, emit;

  assign in_ready = !run;
  assign start    = in_valid && in_ready;
  assign is_out   = (cw.op == scts_pkg::OP_OUT_SC) || (cw.op == scts_pkg::OP_OUT_TAN);
  // hold the output step while the result slot is occupied and not being taken
  assign stall    = run && is_out && out_valid_r && !out_ready;
  assign dp_op    = (run && !stall) ? cw.op : scts_pkg::OP_NOP;
  assign emit     = run && is_out && !stall;

  scts_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stall (stall),
    .stat  (stat),
    .cw    (cw),
    .run   (run)
  );

  scts_dp #(.TERMS(TERMS)) u_dp (
    .clk     (clk),
    .load    (start),
    .in_item (in_data),
    .op      (dp_op),
    .stat    (stat),
    .res     (res)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)                        out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (emit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/scts_checker.sv @@
// scts_checker: port-level assertions for the series block, bound to the top.
// Depends on scts_pkg and sine_cosine_tangent_series_top.
module scts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input scts_pkg::scts_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input scts_pkg::scts_out_t out_data
);

  // A waiting input item is held steady
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while waiting");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Overflow only comes with a saturated value
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      (out_data.value == 32'sh7FFF_FFFF) || (out_data.value == 32'sh8000_0000))
    else $error("overflow without saturation");

  // One item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two items back to back");

  // No result can appear the cycle after an accept
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early after accept");

endmodule

bind sine_cosine_tangent_series_top scts_checker u_scts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
